// ===== design/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared codes, types and lane arithmetic for the saturating stripe
// accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssa_pkg;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_ACCUM = 2'd1,
    ACT_TRUNC = 2'd2
  } action_t;

  localparam logic KIND_ACC   = 1'b0;
  localparam logic KIND_TRUNC = 1'b1;

  localparam logic [1:0] REG_PRECISION   = 2'd0;
  localparam logic [1:0] REG_CLIP_SHIFT  = 2'd1;
  localparam logic [1:0] REG_BATCH_COUNT = 2'd2;

  localparam logic [31:0] I32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] I32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } lane_res_t;

  // One lane of an accumulate: entries pinned at either rail stay there.
  function automatic lane_res_t lane_accum(input logic [31:0] cur,
                                           input logic [15:0] ps,
                                           input logic        prec);
    logic [15:0]        ext;
    logic signed [32:0] sum;
    lane_res_t          res;
    ext = prec ? ps : {{8{ps[7]}}, ps[7:0]};
    sum = $signed({cur[31], cur}) + $signed({{17{ext[15]}}, ext});
    if (cur == I32_MAX || cur == I32_MIN) begin
      res.value = cur;
      res.sat   = 1'b0;
    end else begin
      if (sum >= $signed({1'b0, I32_MAX})) begin
        res.value = I32_MAX;
      end else if (sum <= $signed({1'b1, I32_MIN})) begin
        res.value = I32_MIN;
      end else begin
        res.value = sum[31:0];
      end
      res.sat = (res.value == I32_MAX) || (res.value == I32_MIN);
    end
    return res;
  endfunction

  // Round-half-up shift of the magnitude, with the sign put back afterwards.
  function automatic logic [31:0] round_shift(input logic [31:0] x,
                                              input logic [4:0]  s);
    logic        neg;
    logic [32:0] mag;
    logic [32:0] bias;
    logic [32:0] q;
    neg  = x[31];
    mag  = neg ? (33'd0 - {1'b1, x}) : {1'b0, x};
    bias = (s == 5'd0) ? 33'd0 : (33'd1 << (s - 5'd1));
    q    = (mag + bias) >> s;
    return neg ? 32'(33'd0 - q) : q[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/ssa_store.sv =====
// ----------------------------------------------------------------------------
// ssa_store
// Stripe entry memory: one row per stripe index holding every lane, with a
// registered read port, a write port and per-row valid bits so that a clear
// takes effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_store #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             clear,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // A row never written since the last clear reads as zero.
  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ===== design/saturating_stripe_accumulator.sv =====
// Accumulate: the stripe row is read as the word is accepted, then updated, written back
// and its result strobed on out_valid; busy for one cycle, so no new word is taken
// until the read-modify-write of the stripe row in the entry memory is done. Truncate:
// DEPTH results on consecutive cycles, one memory row read per cycle; the block takes
// a new word only after the last row read and a drain state. A start word keeps it idle.
// Reset invalidates every row at once and resets index, total and configuration registers.
// ----------------------------------------------------------------------------
// saturating_stripe_accumulator
// Per-lane saturating accumulator over stripe entries with rounded truncate.
// ----------------------------------------------------------------------------
`default_nettype none

module saturating_stripe_accumulator #(
  parameter int LANES = 4,
  parameter int DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [63:0] in_partial_sums,
  output logic             out_valid,
  output logic             out_kind,
  output logic [4:0]       out_entry_index,
  output logic [31:0]      out_lane0_value,
  output logic [31:0]      out_lane1_value,
  output logic [31:0]      out_lane2_value,
  output logic [31:0]      out_lane3_value,
  output logic [31:0]      out_saturation_total,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ssa_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int RW = LANES * 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_TRUNC,
    ST_DRAIN
  } state_t;

  state_t          state_r;
  logic [IW-1:0]   issue_idx_r;
  logic [IW-1:0]   stripe_idx_r;
  logic [31:0]     sat_total_r;
  logic            pend_r;
  logic            pend_kind_r;
  logic [IW-1:0]   pend_idx_r;
  logic [63:0]     ps_r;

  logic            precision_r;
  logic [4:0]      clip_shift_r;
  logic [5:0]      batch_count_r;

  logic            out_valid_r;
  logic            out_kind_r;
  logic [4:0]      out_idx_r;
  logic            out_last_r;
  logic [31:0]     out_lane_r [LANES];

  logic            accept;
  action_t         act;
  logic            cfg_wr;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic [RW-1:0]   rd_data;
  logic            wr_en;
  logic [RW-1:0]   row_nxt;
  logic [31:0]     lane_nxt [LANES];
  logic [31:0]     sat_total_nxt;
  logic [IW-1:0]   stripe_nxt;
  logic [6:0]      idx_inc;
  logic [6:0]      eff_count;
  logic [31:0]     lane_out [4];

  assign accept = start && !busy;
  assign act    = action_t'(in_action);
  assign busy   = (state_r != ST_IDLE);

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precision_r   <= 1'b0;
      clip_shift_r  <= 5'd0;
      batch_count_r <= 6'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PRECISION:   precision_r   <= pwdata[0];
        REG_CLIP_SHIFT:  clip_shift_r  <= pwdata[4:0];
        REG_BATCH_COUNT: batch_count_r <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PRECISION:   prdata = {31'd0, precision_r};
      REG_CLIP_SHIFT:  prdata = {27'd0, clip_shift_r};
      REG_BATCH_COUNT: prdata = {26'd0, batch_count_r};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Entry memory
  // ---------------------------------------------------------------------------
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = stripe_idx_r;
    if (state_r == ST_TRUNC) begin
      rd_en   = 1'b1;
      rd_addr = issue_idx_r;
    end else if (accept && act == ACT_ACCUM) begin
      rd_en   = 1'b1;
      rd_addr = stripe_idx_r;
    end else if (accept && act == ACT_TRUNC) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end
  end

  // The FSM leaves no gap for a read to meet the write of the same row:
  // a new word is only taken once the write-back has happened.
  assign wr_en = pend_r && (pend_kind_r == KIND_ACC);

  ssa_store #(
    .DEPTH (DEPTH),
    .WIDTH (RW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (accept && act == ACT_START),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (pend_idx_r),
    .wr_data (row_nxt)
  );

  // ---------------------------------------------------------------------------
  // Lane arithmetic on the row just read
  // ---------------------------------------------------------------------------
  always_comb begin
    lane_res_t  res;
    logic [2:0] sat_count;
    sat_count = 3'd0;
    row_nxt   = '0;
    for (int i = 0; i < LANES; i++) begin
      if (pend_kind_r == KIND_ACC) begin
        res = lane_accum(rd_data[32*i +: 32], ps_r[16*i +: 16], precision_r);
      end else begin
        res.value = round_shift(rd_data[32*i +: 32], clip_shift_r);
        res.sat   = 1'b0;
      end
      lane_nxt[i]          = res.value;
      row_nxt[32*i +: 32]  = res.value;
      sat_count            = sat_count + {2'd0, res.sat};
    end
    sat_total_nxt = sat_total_r + {29'd0, sat_count};
  end

  assign idx_inc   = 7'(pend_idx_r) + 7'd1;
  assign eff_count = (batch_count_r == 6'd0 || 7'(batch_count_r) > 7'(DEPTH))
                     ? 7'(DEPTH) : 7'(batch_count_r);
  assign stripe_nxt = (idx_inc >= eff_count) ? '0 : idx_inc[IW-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_idx_r  <= '0;
      stripe_idx_r <= '0;
      sat_total_r  <= 32'd0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_r      <= rd_en;
      out_valid_r <= pend_r;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (act)
              ACT_START: begin
                stripe_idx_r <= '0;
                sat_total_r  <= 32'd0;
              end
              ACT_ACCUM: state_r <= ST_ACC;
              ACT_TRUNC: begin
                issue_idx_r <= IW'(1);
                state_r     <= ST_TRUNC;
              end
              default: ;
            endcase
          end
        end
        ST_ACC: begin
          sat_total_r  <= sat_total_nxt;
          stripe_idx_r <= stripe_nxt;
          state_r      <= ST_IDLE;
        end
        ST_TRUNC: begin
          if (issue_idx_r == IW'(DEPTH - 1)) begin
            state_r <= ST_DRAIN;
          end else begin
            issue_idx_r <= issue_idx_r + IW'(1);
          end
        end
        ST_DRAIN: state_r <= ST_IDLE;
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_idx_r  <= rd_addr;
      pend_kind_r <= (state_r == ST_TRUNC || act == ACT_TRUNC) ? KIND_TRUNC : KIND_ACC;
    end
    if (accept) begin
      ps_r <= in_partial_sums;
    end
    if (pend_r) begin
      out_kind_r <= pend_kind_r;
      out_idx_r  <= 5'(pend_idx_r);
      out_last_r <= (pend_kind_r == KIND_ACC) || (pend_idx_r == IW'(DEPTH - 1));
      for (int i = 0; i < LANES; i++) begin
        out_lane_r[i] <= lane_nxt[i];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane_out
    if (g < LANES) begin : g_used
      assign lane_out[g] = out_lane_r[g];
    end else begin : g_unused
      assign lane_out[g] = 32'd0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_entry_index      = out_idx_r;
  assign out_lane0_value      = lane_out[0];
  assign out_lane1_value      = lane_out[1];
  assign out_lane2_value      = lane_out[2];
  assign out_lane3_value      = lane_out[3];
  assign out_saturation_total = sat_total_r;
  assign out_last             = out_last_r;

`ifndef SYNTHESIS
  // An idle sequencer has no row read in flight.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_r)
    else $error("row read pending while idle");

  // Every accumulate result closes its word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_ACC) |-> out_last)
    else $error("accumulate result without last");

  // Truncated entries come out back to back in ascending order.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_TRUNC && !out_last) |=>
      (out_valid && out_entry_index == 5'($past(out_entry_index) + 5'd1)))
    else $error("truncate sequence broken");

  // A start word clears the saturation total.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && act == ACT_START) |=> (sat_total_r == 32'd0))
    else $error("saturation total not cleared by start");
`endif

endmodule

`default_nettype wire
